// ===== hw/rtl/svn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svn_pkg
// Shared types and fixed constants of the smooth vertex normal block.
// ----------------------------------------------------------------------------
package svn_pkg;

  localparam int IDX_IN_W  = 10;
  localparam int POS_IN_W  = 16;
  localparam int OUT_W     = 16;
  localparam int FRAC_BITS = 14;
  localparam int A_W       = 24;
  localparam int SQ_W      = 2 * A_W + 2;
  localparam int ROOT_W    = SQ_W / 2;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int MUL_LAST  = 6;
  localparam int SQ_LAST   = 3;
  localparam int SQRT_LAST = ROOT_W - 1;
  localparam int DIV_LAST  = Q_W - 1;

  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_TRI   = 2'd1,
    FN_READ  = 2'd2,
    FN_CLEAR = 2'd3
  } func_t;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_DISPATCH,
    S_TRI_VRD,
    S_TRI_VCAP,
    S_TRI_EDGE,
    S_TRI_MUL,
    S_TRI_SRD,
    S_TRI_SWR,
    S_RD_MAG,
    S_RD_SHIFT,
    S_RD_SQ,
    S_RD_SQI,
    S_RD_SQRT,
    S_RD_LCHK,
    S_RD_DIVI,
    S_RD_DIV,
    S_RD_DSTO,
    S_RD_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic vtx_wr;
    logic vtx_rd;
    logic pos_cap;
    logic edge_ld;
    logic cnt_clr;
    logic cnt_inc;
    logic crn_clr;
    logic crn_inc;
    logic mul_step;
    logic sum_rd;
    logic sum_wr;
    logic sum_clr;
    logic nrm_clr;
    logic mag_ld;
    logic mag_shift;
    logic sq_step;
    logic sqrt_init;
    logic sqrt_step;
    logic comp_clr;
    logic comp_inc;
    logic div_init;
    logic div_step;
    logic div_store;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  in_range;
    logic  tri_ok;
    logic  crn_last;
    logic  comp_last;
    logic  sweep_last;
    logic  mul_last;
    logic  sq_last;
    logic  sqrt_last;
    logic  div_last;
    logic  mag_big;
    logic  len_zero;
    logic  out_free;
  } sts_t;

endpackage

// ===== hw/rtl/svn_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svn_ctrl
// Sequencer: steps the datapath through write, triangle, read and clear.
// ----------------------------------------------------------------------------
module svn_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  svn_pkg::sts_t sts,
  output svn_pkg::cmd_t cmd
);
  import svn_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:      if (sts.sweep_last) state_nxt = S_IDLE;
      S_IDLE:     if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        unique case (sts.func)
          FN_WRITE: state_nxt = S_IDLE;
          FN_TRI:   state_nxt = sts.tri_ok ? S_TRI_VRD : S_IDLE;
          FN_READ:  state_nxt = sts.in_range ? S_RD_MAG : S_RD_OUT;
          FN_CLEAR: state_nxt = S_CLR;
        endcase
      end
      S_TRI_VRD:  if (sts.crn_last) state_nxt = S_TRI_VCAP;
      S_TRI_VCAP: state_nxt = S_TRI_EDGE;
      S_TRI_EDGE: state_nxt = S_TRI_MUL;
      S_TRI_MUL:  if (sts.mul_last) state_nxt = S_TRI_SRD;
      S_TRI_SRD:  state_nxt = S_TRI_SWR;
      S_TRI_SWR:  state_nxt = sts.crn_last ? S_IDLE : S_TRI_SRD;
      S_RD_MAG:   state_nxt = S_RD_SHIFT;
      S_RD_SHIFT: if (!sts.mag_big) state_nxt = S_RD_SQ;
      S_RD_SQ:    if (sts.sq_last) state_nxt = S_RD_SQI;
      S_RD_SQI:   state_nxt = S_RD_SQRT;
      S_RD_SQRT:  if (sts.sqrt_last) state_nxt = S_RD_LCHK;
      S_RD_LCHK:  state_nxt = sts.len_zero ? S_RD_OUT : S_RD_DIVI;
      S_RD_DIVI:  state_nxt = S_RD_DIV;
      S_RD_DIV:   if (sts.div_last) state_nxt = S_RD_DSTO;
      S_RD_DSTO:  state_nxt = sts.comp_last ? S_RD_OUT : S_RD_DIVI;
      S_RD_OUT:   if (sts.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.sum_wr  = 1'b1;
        cmd.sum_clr = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      S_IDLE: cmd.load_in = in_valid;
      S_DISPATCH: begin
        cmd.cnt_clr = 1'b1;
        cmd.crn_clr = 1'b1;
        cmd.nrm_clr = 1'b1;
        cmd.vtx_wr  = (sts.func == FN_WRITE) && sts.in_range;
        cmd.sum_rd  = (sts.func == FN_READ) && sts.in_range;
      end
      S_TRI_VRD: begin
        // shift chain drops the first capture, ends with a, b, c in place
        cmd.vtx_rd  = 1'b1;
        cmd.pos_cap = 1'b1;
        cmd.crn_inc = 1'b1;
      end
      S_TRI_VCAP: begin
        cmd.pos_cap = 1'b1;
        cmd.crn_clr = 1'b1;
      end
      S_TRI_EDGE: begin
        cmd.edge_ld = 1'b1;
        cmd.cnt_clr = 1'b1;
      end
      S_TRI_MUL: begin
        cmd.mul_step = 1'b1;
        cmd.cnt_inc  = 1'b1;
      end
      S_TRI_SRD: cmd.sum_rd = 1'b1;
      S_TRI_SWR: begin
        cmd.sum_wr  = 1'b1;
        cmd.crn_inc = 1'b1;
      end
      S_RD_MAG: cmd.mag_ld = 1'b1;
      S_RD_SHIFT: begin
        cmd.mag_shift = sts.mag_big;
        cmd.cnt_clr   = 1'b1;
      end
      S_RD_SQ: begin
        cmd.sq_step = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      S_RD_SQI: begin
        cmd.sqrt_init = 1'b1;
        cmd.cnt_clr   = 1'b1;
      end
      S_RD_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cmd.cnt_inc   = 1'b1;
      end
      S_RD_LCHK: cmd.comp_clr = 1'b1;
      S_RD_DIVI: begin
        cmd.div_init = 1'b1;
        cmd.cnt_clr  = 1'b1;
      end
      S_RD_DIV: begin
        cmd.div_step = 1'b1;
        cmd.cnt_inc  = 1'b1;
      end
      S_RD_DSTO: begin
        cmd.div_store = 1'b1;
        cmd.comp_inc  = 1'b1;
      end
      S_RD_OUT: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_DISPATCH))
    else $error("accepted word not dispatched");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result overwrites a word still waiting");

  a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TRI_SWR) |-> ($past(state_r) == S_TRI_SRD))
    else $error("sum write without preceding read");

  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR && sts.sweep_last) |=> (state_r == S_IDLE))
    else $error("clear sweep did not end");

endmodule

// ===== hw/rtl/svn_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svn_dp
// Datapath: vertex and sum memories, shared multiplier, root and divide.
// ----------------------------------------------------------------------------
module svn_dp #(
  parameter int VERTEX_COUNT = 1024,
  parameter int COORD_BITS   = 16,
  parameter int SUM_BITS     = 48
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  svn_pkg::cmd_t                          cmd,
  output svn_pkg::sts_t                          sts,
  input  logic [1:0]                             in_func,
  input  logic [svn_pkg::IDX_IN_W-1:0]           in_vertex_index,
  input  logic signed [svn_pkg::POS_IN_W-1:0]    in_pos_x,
  input  logic signed [svn_pkg::POS_IN_W-1:0]    in_pos_y,
  input  logic signed [svn_pkg::POS_IN_W-1:0]    in_pos_z,
  input  logic [svn_pkg::IDX_IN_W-1:0]           in_corner_a,
  input  logic [svn_pkg::IDX_IN_W-1:0]           in_corner_b,
  input  logic [svn_pkg::IDX_IN_W-1:0]           in_corner_c,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [svn_pkg::IDX_IN_W-1:0]           out_normal_index,
  output logic signed [svn_pkg::OUT_W-1:0]       out_normal_x,
  output logic signed [svn_pkg::OUT_W-1:0]       out_normal_y,
  output logic signed [svn_pkg::OUT_W-1:0]       out_normal_z
);
  import svn_pkg::*;

  localparam int IDX_W = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int CNT_W = (IDX_W > 5) ? IDX_W : 5;
  localparam int EW    = COORD_BITS + 1;
  localparam int NW    = 2 * EW + 1;
  localparam int MW    = (EW > A_W + 1) ? EW : A_W + 1;
  localparam int PW    = 2 * MW;
  localparam int SW    = ((SUM_BITS > NW) ? SUM_BITS : NW) + 1;
  localparam int DR_W  = ROOT_W + 1;
  localparam int NUM_W = A_W + FRAC_BITS + 1;
  localparam int VW    = 3 * COORD_BITS;
  localparam int MEM_W = 3 * SUM_BITS;

  function automatic logic [IDX_W-1:0] to_addr(input logic [IDX_IN_W-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[IDX_W-1:0];
  endfunction

  function automatic logic in_rng(input logic [IDX_IN_W-1:0] v);
    return 32'(v) < 32'(VERTEX_COUNT);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] coord_in(input logic [POS_IN_W-1:0] p);
    logic [31:0] t;
    t = 32'(p);
    return signed'(t[COORD_BITS-1:0]);
  endfunction

  function automatic logic signed [SUM_BITS-1:0] sat_add(
    input logic signed [SUM_BITS-1:0] s,
    input logic signed [NW-1:0]       d
  );
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = '0;
    hi[SUM_BITS-2:0] = '1;
    lo = ~hi;
    t = SW'(s) + SW'(d);
    if (t > hi) begin
      return signed'(hi[SUM_BITS-1:0]);
    end else if (t < lo) begin
      return signed'(lo[SUM_BITS-1:0]);
    end
    return signed'(t[SUM_BITS-1:0]);
  endfunction

  // input word
  func_t                       func_r;
  logic [IDX_IN_W-1:0]         idx_r;
  logic [VW-1:0]               pos_r;
  logic [IDX_IN_W-1:0]         crn_in_r [3];

  // control counters
  logic [CNT_W-1:0]            cnt_r;
  logic [1:0]                  crn_r;
  logic [1:0]                  comp_r;

  // memories
  logic [VW-1:0]               vtx_mem [VERTEX_COUNT];
  logic [VW-1:0]               vq_r;
  logic [MEM_W-1:0]            sum_mem [VERTEX_COUNT];
  logic [MEM_W-1:0]            sum_q_r;

  // triangle path
  logic [VW-1:0]               pa_r, pb_r, pc_r;
  logic signed [EW-1:0]        e1_r [3];
  logic signed [EW-1:0]        e2_r [3];
  logic signed [NW-1:0]        n_r [3];
  logic signed [PW-1:0]        prod_r;
  logic signed [MW-1:0]        ma, mb;

  // normalize path
  logic [SUM_BITS-1:0]         mag_r [3];
  logic [2:0]                  sgn_r;
  logic [SQ_W-1:0]             acc_r;
  logic [SQ_W-1:0]             v_r;
  logic [DR_W-1:0]             rem_r;
  logic [ROOT_W-1:0]           root_r;
  logic [DR_W-1:0]             drem_r;
  logic [Q_W-1:0]              nlo_r;
  logic [Q_W-1:0]              q_r;
  logic signed [OUT_W-1:0]     nrm_r [3];

  logic                        out_valid_r;
  logic [IDX_IN_W-1:0]         out_idx_r;
  logic signed [OUT_W-1:0]     out_x_r, out_y_r, out_z_r;

  logic [IDX_IN_W-1:0]         crn_sel;
  logic [IDX_W-1:0]            sum_ra, sum_wa;
  logic [MEM_W-1:0]            sum_wd;
  logic [A_W-1:0]              a_cur;
  logic [NUM_W-1:0]            num;
  logic [DR_W+1:0]             remx;
  logic [DR_W+1:0]             trial;
  logic [DR_W:0]               dremx;
  logic [OUT_W-1:0]            qx;

  always_comb begin
    unique case (crn_r)
      2'd0:    crn_sel = crn_in_r[0];
      2'd1:    crn_sel = crn_in_r[1];
      default: crn_sel = crn_in_r[2];
    endcase
  end

  // status
  always_comb begin
    sts.func       = func_r;
    sts.in_range   = in_rng(idx_r);
    sts.tri_ok     = in_rng(crn_in_r[0]) && in_rng(crn_in_r[1]) && in_rng(crn_in_r[2]);
    sts.crn_last   = (crn_r == 2'd2);
    sts.comp_last  = (comp_r == 2'd2);
    sts.sweep_last = (cnt_r == CNT_W'(VERTEX_COUNT - 1));
    sts.mul_last   = (cnt_r == CNT_W'(MUL_LAST));
    sts.sq_last    = (cnt_r == CNT_W'(SQ_LAST));
    sts.sqrt_last  = (cnt_r == CNT_W'(SQRT_LAST));
    sts.div_last   = (cnt_r == CNT_W'(DIV_LAST));
    sts.mag_big    = (|(mag_r[0] >> A_W)) || (|(mag_r[1] >> A_W)) || (|(mag_r[2] >> A_W));
    sts.len_zero   = (root_r == '0);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r      <= func_t'(in_func);
      idx_r       <= in_vertex_index;
      pos_r       <= {coord_in(in_pos_z), coord_in(in_pos_y), coord_in(in_pos_x)};
      crn_in_r[0] <= in_corner_a;
      crn_in_r[1] <= in_corner_b;
      crn_in_r[2] <= in_corner_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      crn_r  <= '0;
      comp_r <= '0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.crn_clr) begin
        crn_r <= '0;
      end else if (cmd.crn_inc) begin
        crn_r <= crn_r + 2'd1;
      end
      if (cmd.comp_clr) begin
        comp_r <= '0;
      end else if (cmd.comp_inc) begin
        comp_r <= comp_r + 2'd1;
      end
    end
  end

  // vertex memory
  always_ff @(posedge clk) begin
    if (cmd.vtx_wr) begin
      vtx_mem[to_addr(idx_r)] <= pos_r;
    end
    if (cmd.vtx_rd) begin
      vq_r <= vtx_mem[to_addr(crn_sel)];
    end
  end

  // sum memory, read-modify-write per corner
  always_comb begin
    sum_ra = (func_r == FN_TRI) ? to_addr(crn_sel) : to_addr(idx_r);
    sum_wa = cmd.sum_clr ? cnt_r[IDX_W-1:0] : to_addr(crn_sel);
    if (cmd.sum_clr) begin
      sum_wd = '0;
    end else begin
      sum_wd = {sat_add(signed'(sum_q_r[2*SUM_BITS +: SUM_BITS]), n_r[2]),
                sat_add(signed'(sum_q_r[SUM_BITS +: SUM_BITS]), n_r[1]),
                sat_add(signed'(sum_q_r[0 +: SUM_BITS]), n_r[0])};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_wr) begin
      sum_mem[sum_wa] <= sum_wd;
    end
    if (cmd.sum_rd) begin
      sum_q_r <= sum_mem[sum_ra];
    end
  end

  // corner positions and edges
  always_ff @(posedge clk) begin
    if (cmd.pos_cap) begin
      pa_r <= pb_r;
      pb_r <= pc_r;
      pc_r <= vq_r;
    end
    if (cmd.edge_ld) begin
      for (int k = 0; k < 3; k++) begin
        e1_r[k] <= EW'(signed'(pb_r[k*COORD_BITS +: COORD_BITS]))
                 - EW'(signed'(pa_r[k*COORD_BITS +: COORD_BITS]));
        e2_r[k] <= EW'(signed'(pc_r[k*COORD_BITS +: COORD_BITS]))
                 - EW'(signed'(pa_r[k*COORD_BITS +: COORD_BITS]));
      end
    end
  end

  // shared multiplier: cross product terms, then squares of the reduced sum
  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    a_cur = mag_r[0][A_W-1:0];
      2'd1:    a_cur = mag_r[1][A_W-1:0];
      default: a_cur = mag_r[2][A_W-1:0];
    endcase
    if (cmd.sq_step) begin
      ma = signed'(MW'(a_cur));
      mb = signed'(MW'(a_cur));
    end else begin
      unique case (cnt_r[2:0])
        3'd0:    begin ma = MW'(e1_r[1]); mb = MW'(e2_r[2]); end
        3'd1:    begin ma = MW'(e1_r[2]); mb = MW'(e2_r[1]); end
        3'd2:    begin ma = MW'(e1_r[2]); mb = MW'(e2_r[0]); end
        3'd3:    begin ma = MW'(e1_r[0]); mb = MW'(e2_r[2]); end
        3'd4:    begin ma = MW'(e1_r[0]); mb = MW'(e2_r[1]); end
        default: begin ma = MW'(e1_r[1]); mb = MW'(e2_r[0]); end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_step || cmd.sq_step) begin
      prod_r <= ma * mb;
    end
    if (cmd.mul_step) begin
      // fold the product of the previous step
      unique case (cnt_r[2:0])
        3'd1:    n_r[0] <= NW'(prod_r);
        3'd2:    n_r[0] <= n_r[0] - NW'(prod_r);
        3'd3:    n_r[1] <= NW'(prod_r);
        3'd4:    n_r[1] <= n_r[1] - NW'(prod_r);
        3'd5:    n_r[2] <= NW'(prod_r);
        3'd6:    n_r[2] <= n_r[2] - NW'(prod_r);
        default: ;
      endcase
    end
    if (cmd.sq_step) begin
      if (cnt_r[2:0] == 3'd1) begin
        acc_r <= prod_r[SQ_W-1:0];
      end else if (cnt_r[2:0] != 3'd0) begin
        acc_r <= acc_r + prod_r[SQ_W-1:0];
      end
    end
  end

  // magnitudes, shared right shift until all fit in A_W bits
  always_ff @(posedge clk) begin
    if (cmd.mag_ld) begin
      for (int k = 0; k < 3; k++) begin
        sgn_r[k] <= sum_q_r[k*SUM_BITS + SUM_BITS - 1];
        mag_r[k] <= sum_q_r[k*SUM_BITS + SUM_BITS - 1]
                  ? (~sum_q_r[k*SUM_BITS +: SUM_BITS]) + SUM_BITS'(1)
                  : sum_q_r[k*SUM_BITS +: SUM_BITS];
      end
    end else if (cmd.mag_shift) begin
      for (int k = 0; k < 3; k++) begin
        mag_r[k] <= mag_r[k] >> 1;
      end
    end
  end

  // integer square root, one result bit per step
  always_comb begin
    remx  = {rem_r, v_r[SQ_W-1 -: 2]};
    trial = (DR_W+2)'({root_r, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      v_r    <= acc_r;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      v_r <= v_r << 2;
      if (remx >= trial) begin
        rem_r  <= DR_W'(remx - trial);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= DR_W'(remx);
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // rounded divide, one quotient bit per step
  always_comb begin
    unique case (comp_r)
      2'd0:    num = NUM_W'({mag_r[0][A_W-1:0], {FRAC_BITS{1'b0}}});
      2'd1:    num = NUM_W'({mag_r[1][A_W-1:0], {FRAC_BITS{1'b0}}});
      default: num = NUM_W'({mag_r[2][A_W-1:0], {FRAC_BITS{1'b0}}});
    endcase
    num   = num + NUM_W'(root_r >> 1);
    dremx = {drem_r, nlo_r[Q_W-1]};
    qx    = OUT_W'(q_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      drem_r <= DR_W'(num >> Q_W);
      nlo_r  <= num[Q_W-1:0];
      q_r    <= '0;
    end else if (cmd.div_step) begin
      nlo_r <= nlo_r << 1;
      if (dremx >= (DR_W+1)'(root_r)) begin
        drem_r <= DR_W'(dremx - (DR_W+1)'(root_r));
        q_r    <= {q_r[Q_W-2:0], 1'b1};
      end else begin
        drem_r <= DR_W'(dremx);
        q_r    <= {q_r[Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.nrm_clr) begin
      for (int k = 0; k < 3; k++) begin
        nrm_r[k] <= '0;
      end
    end else if (cmd.div_store) begin
      unique case (comp_r)
        2'd0:    nrm_r[0] <= sgn_r[0] ? signed'(-qx) : signed'(qx);
        2'd1:    nrm_r[1] <= sgn_r[1] ? signed'(-qx) : signed'(qx);
        default: nrm_r[2] <= sgn_r[2] ? signed'(-qx) : signed'(qx);
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_idx_r <= idx_r;
      out_x_r   <= nrm_r[0];
      out_y_r   <= nrm_r[1];
      out_z_r   <= nrm_r[2];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_normal_index = out_idx_r;
  assign out_normal_x     = out_x_r;
  assign out_normal_y     = out_y_r;
  assign out_normal_z     = out_z_r;

endmodule

// ===== hw/rtl/smooth_vertex_normals_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smooth_vertex_normals_top
// Area-weighted smooth vertex normals over an indexed triangle mesh.
// ----------------------------------------------------------------------------
// One word is taken at a time. A vertex write is stored from the dispatch
// state; a triangle makes three vertex reads, six products on one shared
// multiplier, then a read-modify-write of each corner's sum; a normal read
// shifts the magnitudes down to A_W bits, squares and sums them, then takes
// 25 root steps and 3 x 15 divide steps; a clear writes one sum entry per
// cycle. After reset the same sweep runs with in_stall high. A finished
// normal waits in the output register while the next word is taken.
module smooth_vertex_normals_top #(
  parameter int VERTEX_COUNT = 1024,
  parameter int COORD_BITS   = 16,
  parameter int SUM_BITS     = 48
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_func,
  input  logic [svn_pkg::IDX_IN_W-1:0]        in_vertex_index,
  input  logic signed [svn_pkg::POS_IN_W-1:0] in_pos_x,
  input  logic signed [svn_pkg::POS_IN_W-1:0] in_pos_y,
  input  logic signed [svn_pkg::POS_IN_W-1:0] in_pos_z,
  input  logic [svn_pkg::IDX_IN_W-1:0]        in_corner_a,
  input  logic [svn_pkg::IDX_IN_W-1:0]        in_corner_b,
  input  logic [svn_pkg::IDX_IN_W-1:0]        in_corner_c,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [svn_pkg::IDX_IN_W-1:0]        out_normal_index,
  output logic signed [svn_pkg::OUT_W-1:0]    out_normal_x,
  output logic signed [svn_pkg::OUT_W-1:0]    out_normal_y,
  output logic signed [svn_pkg::OUT_W-1:0]    out_normal_z
);
  import svn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  svn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  svn_dp #(
    .VERTEX_COUNT (VERTEX_COUNT),
    .COORD_BITS   (COORD_BITS),
    .SUM_BITS     (SUM_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_func),
    .in_vertex_index  (in_vertex_index),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_corner_a      (in_corner_a),
    .in_corner_b      (in_corner_b),
    .in_corner_c      (in_corner_c),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_normal_index (out_normal_index),
    .out_normal_x     (out_normal_x),
    .out_normal_y     (out_normal_y),
    .out_normal_z     (out_normal_z)
  );

endmodule
